// ----- design/csvg_pkg.sv -----
// Shared constants, types and the face basis table for the cube-sphere vertex generator.
package csvg_pkg;

	localparam int RES_W      = 7;
	localparam int FACE_W     = 3;
	localparam int C_W        = 8;
	localparam int AB_W       = 9;
	localparam int SQ_W       = 14;
	localparam int SUM_W      = 15;
	localparam int STRIDE_W   = 8;
	localparam int STR2_W     = 15;
	localparam int R4_W       = 28;
	localparam int T_W        = 29;
	localparam int R6_W       = 42;
	localparam int S_W        = 31;
	localparam int D_W        = 45;
	localparam int F_W        = 31;
	localparam int ROOT_W     = 16;
	localparam int IDX_W      = 16;
	localparam int DIR_W      = 16;
	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 16;
	localparam int UNIT_LAT   = DIV_STEPS + SQRT_STEPS;
	localparam int ADDR_W     = 3;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 128;

	localparam logic [RES_W-1:0] RES_RESET = 7'd32;
	localparam logic [DIR_W-1:0] ONE_Q14   = 16'd16384;
	localparam logic             REG_RES   = 1'b0;
	localparam logic [FACE_W-1:0] FACE_PZ  = 3'd4;

	typedef logic signed [1:0] coef_t;

	// Each row is one face: normal, first axis, second axis. Faces six and seven reuse the +Z row.
	localparam coef_t BASIS [8][9] = '{
		'{ 2'sd1,  2'sd0,  2'sd0,   2'sd0,  2'sd0, -2'sd1,   2'sd0,  2'sd1,  2'sd0},
		'{-2'sd1,  2'sd0,  2'sd0,   2'sd0,  2'sd0,  2'sd1,   2'sd0,  2'sd1,  2'sd0},
		'{ 2'sd0,  2'sd1,  2'sd0,   2'sd1,  2'sd0,  2'sd0,   2'sd0,  2'sd0, -2'sd1},
		'{ 2'sd0, -2'sd1,  2'sd0,   2'sd1,  2'sd0,  2'sd0,   2'sd0,  2'sd0,  2'sd1},
		'{ 2'sd0,  2'sd0,  2'sd1,   2'sd1,  2'sd0,  2'sd0,   2'sd0,  2'sd1,  2'sd0},
		'{ 2'sd0,  2'sd0, -2'sd1,  -2'sd1,  2'sd0,  2'sd0,   2'sd0,  2'sd1,  2'sd0},
		'{ 2'sd0,  2'sd0,  2'sd1,   2'sd1,  2'sd0,  2'sd0,   2'sd0,  2'sd1,  2'sd0},
		'{ 2'sd0,  2'sd0,  2'sd1,   2'sd1,  2'sd0,  2'sd0,   2'sd0,  2'sd1,  2'sd0}
	};

	typedef struct packed {
		logic [2:0]       neg;
		logic             quad_valid;
		logic [IDX_W-1:0] vertex_index;
		logic [IDX_W-1:0] corner0;
		logic [IDX_W-1:0] corner1;
		logic [IDX_W-1:0] corner2;
		logic [IDX_W-1:0] corner3;
	} side_t;

	function automatic logic signed [AB_W-1:0] apply_coef(coef_t k, logic signed [AB_W-1:0] v);
		logic signed [AB_W-1:0] r;
		r = '0;
		if (k == 2'sd1) r = v;
		else if (k == -2'sd1) r = -v;
		return r;
	endfunction

endpackage

// ----- design/csvg_sqrt_ratio.sv -----
// Pipelined sqrt(num/den) in Q1.15 terms: restoring division then an integer square root.
module csvg_sqrt_ratio import csvg_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [D_W-1:0]    num,
	input  logic [D_W-1:0]    den,
	output logic [ROOT_W-1:0] root
);

	logic [D_W-1:0]    rem_s  [DIV_STEPS];
	logic [D_W-1:0]    den_s  [DIV_STEPS];
	logic [F_W-1:0]    quo_s  [DIV_STEPS];
	logic [F_W-1:0]    rad_s  [SQRT_STEPS];
	logic [31:0]       root_s [SQRT_STEPS];

	// The numerator never exceeds the denominator, so the first step settles the integer bit.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (num >= den) ? '0 : num;
			quo_s[0] <= F_W'(num >= den);
			den_s[0] <= den;
		end
	end

	for (genvar j = 1; j < DIV_STEPS; j++) begin : g_div
		logic [D_W:0] sh;
		assign sh = {rem_s[j-1], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_s[j-1];
				if (sh >= {1'b0, den_s[j-1]}) begin
					rem_s[j] <= D_W'(sh - {1'b0, den_s[j-1]});
					quo_s[j] <= {quo_s[j-1][F_W-2:0], 1'b1};
				end else begin
					rem_s[j] <= sh[D_W-1:0];
					quo_s[j] <= {quo_s[j-1][F_W-2:0], 1'b0};
				end
			end
		end
	end

	// The partial root is held scaled by the remaining bit weight, so it needs the full width.
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [31:0] BIT = 32'(1) << (2 * (SQRT_STEPS - 1 - j));
		logic [F_W-1:0]  v_in;
		logic [31:0]     r_in;
		logic [31:0]     trial;
		if (j == 0) begin : g_first
			assign v_in = quo_s[DIV_STEPS-1];
			assign r_in = '0;
		end else begin : g_next
			assign v_in = rad_s[j-1];
			assign r_in = root_s[j-1];
		end
		assign trial = r_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (32'(v_in) >= trial) begin
					rad_s[j]  <= F_W'(32'(v_in) - trial);
					root_s[j] <= (r_in >> 1) + BIT;
				end else begin
					rad_s[j]  <= v_in;
					root_s[j] <= r_in >> 1;
				end
			end
		end
	end

	assign root = root_s[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ----- design/cube_sphere_vertex_generator_top.sv -----
// Top level of the cube-sphere vertex generator: configuration, index and direction pipeline.
//
// Channel   Direction  Word
// s_*       in         face, grid_x, grid_y
// m_*       out        dir_x/y/z, vertex_index, corner indices; quad_valid in tuser
// APB       in/out     face_resolution at byte address 0
//
// One word enters per cycle while the output register is empty or being taken. The pipeline
// holds 6 arithmetic stages, 31 division steps, 16 square-root steps and the output register.
// All stages advance together whenever the output register is empty or being taken,
// so a stall holds every stage in place. Reset clears the valid bits and loads a
// resolution of 32.
module cube_sphere_vertex_generator_top import csvg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // face[2:0], grid_x[9:3], grid_y[16:10], zero fill
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,  // dir_x, dir_y, dir_z, vertex_index, corner 0..3
	output logic [0:0]        m_tuser   // quad_valid
);

	logic [RES_W-1:0] res_q;
	logic             en;

	assign pready   = 1'b1;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
		end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_RES) begin
			res_q <= pwdata[RES_W-1:0];
		end
	end

	assign prdata = (paddr[ADDR_W-1] == REG_RES) ? 32'(res_q) : '0;

	// Input decode: clamp, face coordinates and the cube point.
	logic [FACE_W-1:0]       in_face, bas_face;
	logic [RES_W-1:0]        in_r, in_x, in_y;
	logic signed [AB_W-1:0]  in_a, in_b, in_rs;
	logic signed [C_W-1:0]   in_c [3];

	always_comb begin
		in_face  = s_tdata[2:0];
		bas_face = (in_face > 3'd5) ? FACE_PZ : in_face;
		in_r     = (res_q == '0) ? RES_W'(1) : res_q;
		in_x     = (s_tdata[9:3] > in_r) ? in_r : s_tdata[9:3];
		in_y     = (s_tdata[16:10] > in_r) ? in_r : s_tdata[16:10];
		in_rs    = $signed({2'b00, in_r});
		in_a     = $signed({1'b0, in_x, 1'b0}) - in_rs;
		in_b     = $signed({1'b0, in_y, 1'b0}) - in_rs;
		for (int k = 0; k < 3; k++) begin
			in_c[k] = C_W'(apply_coef(BASIS[bas_face][k], in_rs)
				+ apply_coef(BASIS[bas_face][3+k], in_a)
				+ apply_coef(BASIS[bas_face][6+k], in_b));
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [UNIT_LAT-1:0] v_u;

	logic signed [C_W-1:0]  c_s1 [3];
	logic [RES_W-1:0]       r_s1, x_s1, y_s1;
	logic [FACE_W-1:0]      face_s1;
	logic [STRIDE_W-1:0]    stride_s1;
	logic                   qv_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1      <= in_c;
			r_s1      <= in_r;
			x_s1      <= in_x;
			y_s1      <= in_y;
			face_s1   <= in_face;
			stride_s1 <= STRIDE_W'(in_r) + STRIDE_W'(1);
			qv_s1     <= (in_x < in_r) && (in_y < in_r);
		end
	end

	logic [SQ_W-1:0]     c2_s2 [3];
	logic [2:0]          neg_s2;
	logic [SQ_W-1:0]     r2_s2, ystr_s2;
	logic [STR2_W-1:0]   str2_s2;
	logic [RES_W-1:0]    x_s2;
	logic [FACE_W-1:0]   face_s2;
	logic [STRIDE_W-1:0] stride_s2;
	logic                qv_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				c2_s2[k]  <= SQ_W'(16'(c_s1[k]) * 16'(c_s1[k]));
				neg_s2[k] <= c_s1[k][C_W-1];
			end
			r2_s2     <= SQ_W'(r_s1) * SQ_W'(r_s1);
			ystr_s2   <= SQ_W'(y_s1) * SQ_W'(stride_s1);
			str2_s2   <= STR2_W'(stride_s1) * STR2_W'(stride_s1);
			x_s2      <= x_s1;
			face_s2   <= face_s1;
			stride_s2 <= stride_s1;
			qv_s2     <= qv_s1;
		end
	end

	logic [SQ_W-1:0]     c2_s3 [3];
	logic [SUM_W-1:0]    sum_s3 [3];
	logic [R4_W-1:0]     pq_s3 [3];
	logic [R4_W-1:0]     r4_s3;
	logic [SQ_W-1:0]     r2_s3;
	logic [IDX_W-1:0]    i0_s3;
	logic [2:0]          neg_s3;
	logic [STRIDE_W-1:0] stride_s3;
	logic                qv_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sum_s3[k] <= SUM_W'(c2_s2[(k+1)%3]) + SUM_W'(c2_s2[(k+2)%3]);
				pq_s3[k]  <= R4_W'(c2_s2[(k+1)%3]) * R4_W'(c2_s2[(k+2)%3]);
			end
			c2_s3     <= c2_s2;
			r4_s3     <= R4_W'(r2_s2) * R4_W'(r2_s2);
			r2_s3     <= r2_s2;
			i0_s3     <= IDX_W'(18'(face_s2) * 18'(str2_s2) + 18'(ystr_s2) + 18'(x_s2));
			neg_s3    <= neg_s2;
			stride_s3 <= stride_s2;
			qv_s3     <= qv_s2;
		end
	end

	logic [SQ_W-1:0] c2_s4 [3];
	logic [T_W-1:0]  t_s4 [3];
	logic [R4_W-1:0] pq_s4 [3];
	logic [R4_W-1:0] r4_s4;
	logic [R6_W-1:0] r6_s4;
	side_t           side_s4;
	logic [IDX_W-1:0] corner2_s3;

	assign corner2_s3 = i0_s3 + IDX_W'(stride_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				t_s4[k] <= T_W'(r2_s3) * T_W'(sum_s3[k]);
			end
			c2_s4                <= c2_s3;
			pq_s4                <= pq_s3;
			r4_s4                <= r4_s3;
			r6_s4                <= R6_W'(r4_s3) * R6_W'(r2_s3);
			side_s4.neg          <= neg_s3;
			side_s4.quad_valid   <= qv_s3;
			side_s4.vertex_index <= i0_s3;
			side_s4.corner0      <= qv_s3 ? i0_s3 : '0;
			side_s4.corner1      <= qv_s3 ? i0_s3 + IDX_W'(1) : '0;
			side_s4.corner2      <= qv_s3 ? corner2_s3 : '0;
			side_s4.corner3      <= qv_s3 ? corner2_s3 + IDX_W'(1) : '0;
		end
	end

	logic [SQ_W-1:0] c2_s5 [3];
	logic [S_W-1:0]  s_s5 [3];
	logic [D_W-1:0]  d_s5;
	side_t           side_s5;

	// The weight 6r^4 - 3r^2(p^2+q^2) + 2p^2q^2 is never negative.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				s_s5[k] <= S_W'(33'(r4_s4) * 33'd6 + 33'(pq_s4[k]) * 33'd2
					- 33'(t_s4[k]) * 33'd3);
			end
			c2_s5   <= c2_s4;
			d_s5    <= D_W'(r6_s4) * D_W'(6);
			side_s5 <= side_s4;
		end
	end

	logic [D_W-1:0] n_s6 [3];
	logic [D_W-1:0] d_s6;
	side_t          side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				n_s6[k] <= D_W'(c2_s5[k]) * D_W'(s_s5[k]);
			end
			d_s6    <= d_s5;
			side_s6 <= side_s5;
		end
	end

	logic [ROOT_W-1:0] root [3];

	for (genvar k = 0; k < 3; k++) begin : g_comp
		csvg_sqrt_ratio u_root (
			.clk  (clk),
			.en   (en),
			.num  (n_s6[k]),
			.den  (d_s6),
			.root (root[k])
		);
	end

	side_t side_u [UNIT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			side_u[0] <= side_s6;
			for (int j = 1; j < UNIT_LAT; j++) side_u[j] <= side_u[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_u      <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_u      <= {v_u[UNIT_LAT-2:0], v_s6};
			m_tvalid <= v_u[UNIT_LAT-1];
		end
	end

	// Round half up on the root, clamp to one, then apply the sign.
	logic [DIR_W-1:0] dir [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [ROOT_W:0]  half;
			logic [DIR_W-1:0] mag;
			half = ((ROOT_W+1)'(root[k]) + (ROOT_W+1)'(1)) >> 1;
			mag  = (half[DIR_W-1:0] > ONE_Q14) ? ONE_Q14 : half[DIR_W-1:0];
			dir[k] = side_u[UNIT_LAT-1].neg[k] ? -mag : mag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {side_u[UNIT_LAT-1].corner3, side_u[UNIT_LAT-1].corner2,
				side_u[UNIT_LAT-1].corner1, side_u[UNIT_LAT-1].corner0,
				side_u[UNIT_LAT-1].vertex_index, dir[2], dir[1], dir[0]};
			m_tuser <= side_u[UNIT_LAT-1].quad_valid;
		end
	end

	a_corners_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[127:64] == '0)
		else $error("corner indices not cleared without a quad");

	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[95:80] == m_tdata[79:64] + 16'd1
			&& m_tdata[79:64] == m_tdata[63:48])
		else $error("quad corners inconsistent with vertex index");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[15:0]) <= 16'sd16384
			&& $signed(m_tdata[15:0]) >= -16'sd16384)
		else $error("direction component out of Q1.14 range");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the cube-sphere vertex generator.
module tb;
	import csvg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] dx, dy, dz, vidx;
		logic        qv;
		logic [15:0] c0, c1, c2, c3;
	} vertex_t;

	class vertex_scoreboard;
		vertex_t     pending[$];
		int          mismatches;
		logic [6:0]  res;

		function new();
			mismatches = 0;
			res = RES_RESET;
		endfunction

		// Magnitude of sqrt(n/d) in Q1.14, rounded to nearest.
		function automatic longint unsigned sqrt_q14(longint unsigned n, longint unsigned d);
			longint unsigned f, rem, root, bitv;
			rem = n;
			f = 0;
			if (rem >= d) begin
				f = 1;
				rem -= d;
			end
			for (int i = 0; i < 30; i++) begin
				rem = rem << 1;
				f = f << 1;
				if (rem >= d) begin
					rem -= d;
					f |= 1;
				end
			end
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > f) bitv >>= 2;
			while (bitv != 0) begin
				if (f >= root + bitv) begin
					f -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return (root + 1) >> 1;
		endfunction

		function void note_vertex(logic [2:0] face, logic [6:0] gx, logic [6:0] gy);
			vertex_t v;
			longint r, x, y, a, b, r2, s, p2, q2;
			longint unsigned d, n, mag, stride, i0;
			longint c[3], c2[3];
			int fb;
			r = (res == 0) ? 1 : res;
			x = (gx > r) ? r : gx;
			y = (gy > r) ? r : gy;
			a = 2 * x - r;
			b = 2 * y - r;
			fb = (face > 5) ? 4 : face;
			for (int k = 0; k < 3; k++) begin
				c[k] = BASIS[fb][k] * r + BASIS[fb][3+k] * a + BASIS[fb][6+k] * b;
				c2[k] = c[k] * c[k];
			end
			r2 = r * r;
			d = 6 * r2 * r2 * r2;
			for (int k = 0; k < 3; k++) begin
				p2 = c2[(k+1)%3];
				q2 = c2[(k+2)%3];
				s = 6 * r2 * r2 - 3 * r2 * (p2 + q2) + 2 * p2 * q2;
				n = c2[k] * s;
				if (n > d) n = d;
				mag = sqrt_q14(n, d);
				if (mag > 16384) mag = 16384;
				mag = (c[k] < 0) ? (0 - mag) : mag;
				if (k == 0) v.dx = mag[15:0];
				else if (k == 1) v.dy = mag[15:0];
				else v.dz = mag[15:0];
			end
			stride = r + 1;
			i0 = (face * stride * stride + y * stride + x) & 16'hFFFF;
			v.vidx = i0[15:0];
			v.qv = (x < r) && (y < r);
			v.c0 = v.qv ? i0[15:0] : '0;
			v.c1 = v.qv ? 16'(i0 + 1) : '0;
			v.c2 = v.qv ? 16'(i0 + stride) : '0;
			v.c3 = v.qv ? 16'(i0 + stride + 1) : '0;
			pending.insert(pending.size(), v);
		endfunction

		function void check_vertex(logic [OUT_W-1:0] data, logic qv);
			vertex_t e;
			vertex_t got;
			got.dx = data[15:0];
			got.dy = data[31:16];
			got.dz = data[47:32];
			got.vidx = data[63:48];
			got.c0 = data[79:64];
			got.c1 = data[95:80];
			got.c2 = data[111:96];
			got.c3 = data[127:112];
			got.qv = qv;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected vertex word %h", data);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("vertex mismatch: exp %h %h %h idx %h q %b %h %h %h %h, ",
						e.dx, e.dy, e.dz, e.vidx, e.qv, e.c0, e.c1, e.c2, e.c3,
						"got %h %h %h idx %h q %b %h %h %h %h",
						got.dx, got.dy, got.dz, got.vidx, got.qv, got.c0, got.c1,
						got.c2, got.c3);
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 0;
	logic [OUT_W-1:0]  m_tdata;
	logic [0:0]        m_tuser;
	logic              feeding = 0;
	longint            cycles = 0;

	vertex_scoreboard sb = new();

	cube_sphere_vertex_generator_top u_top (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Receiver: random stalls, except during stretches where it always takes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_vertex(m_tdata, m_tuser[0]);
			m_tready <= feeding ? 1'b1 : (gap_len() == 0);
		end
	end

	task automatic write_res(logic [31:0] val, logic idx);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_RES) sb.res = val[6:0];
	endtask

	// The valid stays high between back-to-back words and drops only before a gap.
	task automatic send_vertex(logic [2:0] face, logic [6:0] gx, logic [6:0] gy);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {7'd0, gy, gx, face};
		do @(posedge clk); while (!s_tready);
		sb.note_vertex(face, gx, gy);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		logic [6:0] r;
		r = (sb.res == 0) ? 7'd1 : sb.res;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 8)
				send_vertex(3'($urandom_range(0, 5)), 7'($urandom_range(0, r)),
					7'($urandom_range(0, r)));
			else
				send_vertex(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
					7'($urandom_range(0, 127)));
		end
	endtask

	initial begin
		logic [6:0] settings[$];
		repeat (5) @(posedge clk);
		arst_n <= 1;
		// Directed: corners, centre, clamping and spare face codes at reset resolution.
		for (int f = 0; f < 8; f++) send_vertex(3'(f), 7'd0, 7'd0);
		send_vertex(3'd0, 7'd32, 7'd32);
		send_vertex(3'd1, 7'd16, 7'd16);
		send_vertex(3'd2, 7'd127, 7'd0);
		send_vertex(3'd3, 7'd0, 7'd127);
		send_vertex(3'd4, 7'd31, 7'd31);
		send_vertex(3'd5, 7'd32, 7'd0);
		send_vertex(3'd7, 7'd127, 7'd127);
		send_vertex(3'd6, 7'd85, 7'd42);
		drain();
		write_res(32'hFFFF_FF00, 1'b1);	// no register at this index
		send_vertex(3'd4, 7'd31, 7'd32);
		drain();
		write_res(32'd0, REG_RES);
		send_vertex(3'd0, 7'd0, 7'd0);
		send_vertex(3'd5, 7'd1, 7'd0);
		send_vertex(3'd2, 7'd5, 7'd9);
		drain();
		write_res(32'hFFFF_FF7F, REG_RES);
		send_vertex(3'd5, 7'd127, 7'd126);
		send_vertex(3'd7, 7'd126, 7'd127);
		drain();
		settings = '{1, 2, 103, 7, 127, 32, 64, 104, 3, 50, 17};
		foreach (settings[i]) begin
			write_res({25'h1FFFFFF, settings[i]}, REG_RES);
			feeding = (i % 3 == 0);
			random_phase(150);
			drain();
		end
		feeding = 0;
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
